[rtl/pdr_pkg.sv]
// Shared constants, types and the arctangent table of the phase derivative rotator.
`default_nettype none
package pdr_pkg;
  localparam int CORDIC_STAGES = 24;
  localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam logic signed [63:0] TWO_PI_Q48 = 64'sh6487ED5110B46;
  localparam logic signed [35:0] PI_Q30 = 36'shC90FDAA2;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sh6487ED51;
  localparam logic signed [35:0] THREE_HALF_PI_Q30 = 36'sh12D97C7F3;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sh1921FB544;
  localparam logic signed [35:0] GAIN_INV_Q30 = 36'sh26DD3B6A;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [31:0] rate;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic signed [35:0] z;
    logic neg;
  } front_item_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0: r = 36'sd843314857;
      5'd1: r = 36'sd497837829;
      5'd2: r = 36'sd263043837;
      5'd3: r = 36'sd133525159;
      5'd4: r = 36'sd67021687;
      5'd5: r = 36'sd33543516;
      5'd6: r = 36'sd16775851;
      5'd7: r = 36'sd8388437;
      5'd8: r = 36'sd4194283;
      5'd9: r = 36'sd2097149;
      5'd31: r = 36'sd0;
      default: r = 36'sd1 <<< (30 - i);
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[rtl/pdr_front.sv]
// Front part: phase product, modulo reduction and quadrant fold, pipelined.
`default_nettype none
module pdr_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic signed [31:0] zone_thickness,
  input  wire logic in_valid,
  input  wire logic signed [31:0] phase_rate,
  input  wire logic signed [31:0] re_in,
  input  wire logic signed [31:0] im_in,
  input  wire logic adv,
  output logic out_valid,
  output pdr_pkg::front_item_t out_item
);
  localparam int RS = 8;
  localparam int FL = RS + 3;
  localparam logic [65:0] TWO_PI = 66'(pdr_pkg::TWO_PI_Q48);
  localparam logic [65:0] OFFSET = TWO_PI << 12;
  logic [FL-1:0] v;
  logic signed [31:0] rate_d [FL];
  logic signed [31:0] re_d [FL];
  logic signed [31:0] im_d [FL];
  logic signed [63:0] prod;
  logic [65:0] rem [RS+1];
  logic signed [35:0] a;

  // The product is offset by a multiple of 2pi so that the floor modulo becomes
  // a chain of compare and subtract steps on a nonnegative value, two per stage.
  function automatic logic [65:0] reduce2(input logic [65:0] r, input int k);
    logic [65:0] s;
    s = r;
    if (s >= (TWO_PI << (k + 1))) s = s - (TWO_PI << (k + 1));
    if (s >= (TWO_PI << k)) s = s - (TWO_PI << k);
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[FL-2:0], in_valid};
    if (adv) begin
      prod <= zone_thickness * phase_rate;
      rate_d[0] <= phase_rate;
      re_d[0] <= re_in;
      im_d[0] <= im_in;
      for (int j = 1; j < FL; j++) begin
        rate_d[j] <= rate_d[j-1];
        re_d[j] <= re_d[j-1];
        im_d[j] <= im_d[j-1];
      end
      rem[0] <= 66'(prod) + OFFSET;
      for (int j = 0; j < RS; j++) rem[j+1] <= reduce2(rem[j], 2 * (RS - 1 - j));
      a <= 36'((rem[RS] + 66'd131072) >> 18);
    end
  end

  always_comb begin
    out_item.rate = rate_d[FL-1];
    out_item.re = re_d[FL-1];
    out_item.im = im_d[FL-1];
    out_item.neg = 1'b0;
    if (a <= pdr_pkg::HALF_PI_Q30) out_item.z = a;
    else if (a < pdr_pkg::THREE_HALF_PI_Q30) begin
      out_item.z = a - pdr_pkg::PI_Q30;
      out_item.neg = 1'b1;
    end else out_item.z = a - pdr_pkg::TWO_PI_Q30;
  end
  assign out_valid = v[FL-1];
endmodule
`default_nettype wire

[rtl/pdr_queue.sv]
// Short item queue between the front and back parts.
`default_nettype none
module pdr_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire pdr_pkg::front_item_t wdata,
  input  wire logic rd,
  output pdr_pkg::front_item_t rdata,
  output logic empty,
  output logic [pdr_pkg::QAW:0] count
);
  pdr_pkg::front_item_t mem [pdr_pkg::QDEPTH];
  logic [pdr_pkg::QAW-1:0] wp, rp;
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (pdr_pkg::QAW+1)'(wr) - (pdr_pkg::QAW+1)'(rd);
    end
    if (wr) mem[wp] <= wdata;
  end
  assign rdata = mem[rp];
  assign empty = (count == '0);
endmodule
`default_nettype wire

[rtl/pdr_back.sv]
// Back part: pipelined CORDIC, complex product and output scaling.
`default_nettype none
module pdr_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire pdr_pkg::front_item_t in_item,
  input  wire logic adv,
  output logic out_valid,
  output logic signed [47:0] re_out,
  output logic signed [47:0] im_out
);
  localparam int N = pdr_pkg::NST;
  localparam int L = N + 4;
  logic [L-1:0] v;
  logic signed [35:0] x [1:N];
  logic signed [35:0] y [1:N];
  logic signed [35:0] z [1:N];
  logic signed [31:0] rate [1:N];
  logic signed [31:0] re [1:N];
  logic signed [31:0] im [1:N];
  logic neg [1:N];

  always_ff @(posedge clk) begin
    if (adv) begin
      x[1] <= pdr_pkg::GAIN_INV_Q30;
      if (in_item.z >= 0) begin
        y[1] <= pdr_pkg::GAIN_INV_Q30;
        z[1] <= in_item.z - pdr_pkg::atan_q30(5'd0);
      end else begin
        y[1] <= -pdr_pkg::GAIN_INV_Q30;
        z[1] <= in_item.z + pdr_pkg::atan_q30(5'd0);
      end
      rate[1] <= in_item.rate; re[1] <= in_item.re; im[1] <= in_item.im;
      neg[1] <= in_item.neg;
      for (int i = 1; i < N; i++) begin
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - pdr_pkg::atan_q30(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + pdr_pkg::atan_q30(5'(i));
        end
        rate[i+1] <= rate[i]; re[i+1] <= re[i]; im[i+1] <= im[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  logic signed [67:0] m1, m2, m3, m4;
  logic signed [31:0] r1, r2;
  logic signed [35:0] t, u;
  logic signed [67:0] pt, pu;
  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[L-2:0], in_valid};
    if (adv) begin
      r1 <= rate[N];
      m1 <= re[N] * (neg[N] ? -y[N] : y[N]);
      m2 <= im[N] * (neg[N] ? -x[N] : x[N]);
      m3 <= re[N] * (neg[N] ? -x[N] : x[N]);
      m4 <= im[N] * (neg[N] ? -y[N] : y[N]);
      t <= 36'((m1 + m2 + 68'sd536870912) >>> 30);
      u <= 36'((m3 - m4 + 68'sd536870912) >>> 30);
      r2 <= r1;
      pt <= r2 * t;
      pu <= r2 * u;
    end
  end

  function automatic logic signed [47:0] sat(input logic signed [68:0] val);
    if (val > 69'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
    if (val < -69'sh800000000000) return -48'sh800000000000;
    return val[47:0];
  endfunction

  logic signed [68:0] ro, io;
  always_comb begin
    ro = -((69'(pt) + 69'sd8388608) >>> 24);
    io = (69'(pu) + 69'sd8388608) >>> 24;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      re_out <= sat(ro);
      im_out <= sat(io);
    end
  end
  assign out_valid = v[L-1];
endmodule
`default_nettype wire

[rtl/phase_derivative_rotator.sv]
// Top level of the phase derivative rotator.
`default_nettype none
// One item is taken per cycle while in_stall is low; without stalls each result is offered after
// its item has passed the front pipeline, the queue, the CORDIC stages and the back part's
// product, rounding, rate product and output registers. The front pipeline stalls while the
// queue holds two items; the back pipeline stalls only while a waiting result is stalled.
module phase_derivative_rotator (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [31:0] phase_rate,
  input  wire logic signed [31:0] re_in,
  input  wire logic signed [31:0] im_in,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [47:0] re_out,
  output logic signed [47:0] im_out
);
  logic signed [31:0] zone_thickness;
  logic fadv, fv, badv, bv, qrd, qempty;
  logic [pdr_pkg::QAW:0] qcount;
  pdr_pkg::front_item_t fitem, qitem;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) zone_thickness <= '0;
    else if (cfg_valid) zone_thickness <= cfg_data;
  end

  // Front may advance while the queue holds fewer than two items.
  assign fadv = (qcount < (pdr_pkg::QAW+1)'(2));
  assign in_stall = !fadv;
  assign badv = !(out_valid && out_stall);
  assign qrd = badv && !qempty;

  pdr_front u_front (.clk, .rst, .zone_thickness, .in_valid, .phase_rate, .re_in, .im_in,
    .adv(fadv), .out_valid(fv), .out_item(fitem));
  pdr_queue u_queue (.clk, .rst, .wr(fv && fadv), .wdata(fitem), .rd(qrd), .rdata(qitem),
    .empty(qempty), .count(qcount));
  pdr_back u_back (.clk, .rst, .in_valid(qrd), .in_item(qitem), .adv(badv), .out_valid(bv),
    .re_out, .im_out);
  assign out_valid = bv;

  a_qcap: assert property (@(posedge clk) disable iff (rst) qcount <= 3'(pdr_pkg::QDEPTH))
    else $error("queue overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(re_out)) else $error("output changed");
  a_qrd: assert property (@(posedge clk) disable iff (rst) qrd |-> !qempty)
    else $error("queue underflow");
endmodule
`default_nettype wire
